@@ hw/rtl/hsg_pkg.sv @@
package hsg_pkg;

    // Sizing
    localparam int MAX_VERTICAL = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int QDEPTH       = 2;

    localparam int VCW = $clog2(MAX_VERTICAL + 1);
    localparam int SW  = $clog2(CORDIC_STEPS);
    localparam int QAW = $clog2(QDEPTH);

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 136;

    // CORDIC constants, angles in units of 2^-32 turn, vectors in Q2.30
    localparam logic signed [32:0] CORDIC_K     = 33'sd652032874;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_VERT  = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP = 2'd1;
    localparam logic [1:0] CFG_LIST_SIZE = 2'd2;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        ang;
        logic signed [32:0] z0;
        logic               flip;
        logic signed [15:0] climb;
        logic [15:0]        gspd;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [3:0]  num_vert;
        logic [15:0] time_step;
        logic [23:0] list_size;
    } t_cfg;

    function automatic logic signed [32:0] atan_turn(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            5'd20:   v = 33'sd652;
            5'd21:   v = 33'sd326;
            5'd22:   v = 33'sd163;
            5'd23:   v = 33'sd81;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/hsg_front.sv @@
module hsg_front import hsg_pkg::*; (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pos_z, heading, climb_rate, ground_speed, heading_offset
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_item                 o_item
);

    logic [15:0]        ang;
    logic signed [32:0] z_raw;

    assign ang   = s_axis_tdata[111:96] + s_axis_tdata[159:144];
    assign z_raw = {ang[15], ang, 16'd0};

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    // Fold the angle into the right half plane; the CORDIC result is negated later.
    always_comb begin
        o_item.px    = s_axis_tdata[31:0];
        o_item.py    = s_axis_tdata[63:32];
        o_item.pz    = s_axis_tdata[95:64];
        o_item.ang   = ang;
        o_item.climb = s_axis_tdata[127:112];
        o_item.gspd  = s_axis_tdata[143:128];
        o_item.last  = s_axis_tlast;
        if (z_raw > QUARTER_TURN) begin
            o_item.z0   = z_raw - HALF_TURN;
            o_item.flip = 1'b1;
        end else if (z_raw < -QUARTER_TURN) begin
            o_item.z0   = z_raw + HALF_TURN;
            o_item.flip = 1'b1;
        end else begin
            o_item.z0   = z_raw;
            o_item.flip = 1'b0;
        end
    end

endmodule

@@ hw/rtl/hsg_queue.sv @@
module hsg_queue import hsg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ hw/rtl/hsg_cordic.sv @@
module hsg_cordic import hsg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_z0,
    output logic               o_done,
    output logic signed [32:0] o_x,
    output logic signed [32:0] o_y
);

    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [32:0] r_z;
    logic [SW-1:0]      r_step;
    logic               r_busy;
    logic               r_done;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] at;

    assign dx     = r_y >>> r_step;
    assign dy     = r_x >>> r_step;
    assign at     = atan_turn(5'(r_step));
    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == SW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_K;
            r_y <= '0;
            r_z <= i_z0;
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

endmodule

@@ hw/rtl/hsg_back.sv @@
module hsg_back import hsg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    input  t_item                  i_q_item,
    output logic                   o_q_pop,
    output logic                   o_cordic_start,
    output logic signed [32:0]     o_cordic_z0,
    input  logic                   i_cordic_done,
    input  logic signed [32:0]     i_cordic_x,
    input  logic signed [32:0]     i_cordic_y,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // child_x, child_y, child_z, child_heading, child_index
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // expansion_done
    output logic                   m_axis_tuser
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROT  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SUM  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [23:0]        r_node_count;
    logic [VCW-1:0]     r_k;
    logic [VCW-1:0]     n_eff;
    logic               fin;
    logic               xfer;

    t_item              r_item;
    logic [31:0]        r_dist;
    logic signed [32:0] r_sn;
    logic signed [32:0] r_cs;
    logic signed [65:0] r_prod_x;
    logic signed [65:0] r_prod_y;
    logic signed [32:0] r_prod_z;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic signed [31:0] r_cz;

    logic signed [65:0] rnd_x;
    logic signed [65:0] rnd_y;
    logic signed [32:0] rnd_z;
    logic [23:0]        child_index;

    assign n_eff = (32'(i_cfg.num_vert) > MAX_VERTICAL) ? VCW'(MAX_VERTICAL)
                                                         : VCW'(i_cfg.num_vert);
    assign fin   = (r_k == VCW'(n_eff - 1'b1));
    assign xfer  = m_axis_tvalid && m_axis_tready;

    // Round to Q24.8, half up.
    assign rnd_x = (r_prod_x + (66'sd1 <<< 37)) >>> 38;
    assign rnd_y = (r_prod_y + (66'sd1 <<< 37)) >>> 38;
    assign rnd_z = (r_prod_z + 33'sd128) >>> 8;

    assign child_index   = i_cfg.list_size + r_node_count + 24'd1;
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign m_axis_tdata  = {child_index, r_item.ang, r_cz, r_cy, r_cx};
    assign m_axis_tlast  = fin;
    assign m_axis_tuser  = fin && r_item.last;
    assign o_cordic_z0   = i_q_item.z0;

    always_comb begin
        n_state        = r_state;
        o_q_pop        = 1'b0;
        o_cordic_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    // With no children configured the item is dropped.
                    if (n_eff != '0) begin
                        o_cordic_start = 1'b1;
                        n_state        = S_ROT;
                    end
                end
            end
            S_ROT: begin
                if (i_cordic_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (xfer && fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= '0;
            r_k          <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_k <= '0;
            end else if (xfer) begin
                r_k          <= r_k + 1'b1;
                r_node_count <= r_node_count + 24'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_ROT) begin
            r_dist <= 32'(r_item.gspd * i_cfg.time_step);
            if (i_cordic_done) begin
                r_sn <= r_item.flip ? -i_cordic_y : i_cordic_y;
                r_cs <= r_item.flip ? -i_cordic_x : i_cordic_x;
            end
        end
        if (r_state == S_MUL) begin
            r_prod_x <= $signed({1'b0, r_dist}) * r_sn;
            r_prod_y <= $signed({1'b0, r_dist}) * r_cs;
            r_prod_z <= r_item.climb * $signed({1'b0, i_cfg.time_step});
        end
        if (r_state == S_SUM) begin
            r_cx <= sat32(34'(r_item.px) + rnd_x[33:0]);
            r_cy <= sat32(34'(r_item.py) + rnd_y[33:0]);
            r_cz <= sat32(34'(r_item.pz) + 34'(rnd_z));
        end
    end

endmodule

@@ hw/rtl/heading_successor_generator.sv @@
// An accepted transfer passes the queue, the CORDIC rotation steps, the multiply and
// the round and saturate stage before its first child is offered. The back end takes
// one input at a time, bounded by the iterative CORDIC; children of one input leave
// one per cycle while m_axis_tready is high. A two-entry queue takes new inputs while
// the back end works. Reset is synchronous, active low; it clears the node counter and
// the queue and restores the register defaults.
module heading_successor_generator import hsg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [23:0]            i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, pos_z, heading, climb_rate, ground_speed, heading_offset
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // last_heading
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // child_x, child_y, child_z, child_heading, child_index
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // last_child
    output logic                   m_axis_tlast,
    // expansion_done
    output logic                   m_axis_tuser
);

    t_cfg               r_cfg;
    logic               q_full;
    logic               q_push;
    t_item              q_in;
    logic               q_valid;
    t_item              q_out;
    logic               q_pop;
    logic               c_start;
    logic signed [32:0] c_z0;
    logic               c_done;
    logic signed [32:0] c_x;
    logic signed [32:0] c_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_vert  <= 4'd1;
            r_cfg.time_step <= 16'd256;
            r_cfg.list_size <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_VERT:  r_cfg.num_vert  <= i_cfg_data[3:0];
                CFG_TIME_STEP: r_cfg.time_step <= i_cfg_data[15:0];
                CFG_LIST_SIZE: r_cfg.list_size <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hsg_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    hsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out),
        .i_pop   (q_pop)
    );

    hsg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_z0    (c_z0),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y)
    );

    hsg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_out),
        .o_q_pop        (q_pop),
        .o_cordic_start (c_start),
        .o_cordic_z0    (c_z0),
        .i_cordic_done  (c_done),
        .i_cordic_x     (c_x),
        .i_cordic_y     (c_y),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser)
    );

endmodule

@@ test/tb_heading_successor_generator.sv @@
module tb_heading_successor_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import hsg_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_PRINTED  = 100;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam longint ROT_START     = 64'sd652032874;
    localparam longint QUARTER_ANGLE = 64'sd1073741824;
    localparam longint HALF_ANGLE    = 64'sd2147483648;
    localparam longint ATAN_STEP [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        heading;
        logic signed [15:0] climb;
        logic [15:0]        gspd;
        logic signed [15:0] offset;
        logic               last_heading;
    } t_parent;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        heading;
        logic [23:0]        index;
        logic               last_child;
        logic               done;
    } t_child;

    class t_child_scoreboard;
        logic [3:0]  num_vert;
        logic [15:0] time_step;
        logic [23:0] list_size;
        logic [23:0] node_count;
        t_child      expected_children[$];
        int          errors;

        function new();
            num_vert   = 4'd1;
            time_step  = 16'd256;
            list_size  = 24'd0;
            node_count = 24'd0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] value);
            case (idx)
                CFG_NUM_VERT:  num_vert = value[3:0];
                CFG_TIME_STEP: time_step = value[15:0];
                CFG_LIST_SIZE: list_size = value;
                default: ;
            endcase
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Rotation-mode CORDIC on a 16-bit binary angle; sine and cosine in Q2.30.
        static function void sin_cos(input logic [15:0] angle, output longint sn,
                                     output longint cs);
            longint z, x, y, dx, dy;
            bit     flip;
            z = longint'(signed'({angle, 16'h0000}));
            x = ROT_START;
            y = 0;
            flip = 1'b0;
            // Fold into the right half plane; the result is mirrored afterwards.
            if (z > QUARTER_ANGLE) begin
                z = z - HALF_ANGLE;
                flip = 1'b1;
            end else if (z < -QUARTER_ANGLE) begin
                z = z + HALF_ANGLE;
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_STEP[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_STEP[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            sn = y;
            cs = x;
        endfunction

        function void note_parent(t_parent p);
            logic [15:0] angle;
            longint      sn, cs, reach, cx, cy, cz;
            int          count;
            t_child      c;
            angle = p.heading + p.offset;
            sin_cos(angle, sn, cs);
            reach = longint'(p.gspd) * longint'(time_step);
            cx = clamp32(longint'(p.pos_x) + ((reach * sn + (64'sd1 <<< 37)) >>> 38));
            cy = clamp32(longint'(p.pos_y) + ((reach * cs + (64'sd1 <<< 37)) >>> 38));
            cz = clamp32(longint'(p.pos_z)
                         + ((longint'(p.climb) * longint'(time_step) + 128) >>> 8));
            count = (num_vert > MAX_VERTICAL) ? MAX_VERTICAL : int'(num_vert);
            for (int k = 0; k < count; k++) begin
                c.x          = cx[31:0];
                c.y          = cy[31:0];
                c.z          = cz[31:0];
                c.heading    = angle;
                c.index      = list_size + node_count + 24'd1;
                c.last_child = (k == count - 1);
                c.done       = c.last_child & p.last_heading;
                expected_children = {expected_children, c};
                node_count = node_count + 24'd1;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
        endtask

        task compare(string name, longint got, longint want);
            if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_child(t_child got);
            t_child want;
            if (expected_children.size() == 0) begin
                report($sformatf("child %0d arrived with nothing pending", got.index));
                return;
            end
            want = expected_children.pop_front();
            compare("child_x", got.x, want.x);
            compare("child_y", got.y, want.y);
            compare("child_z", got.z, want.z);
            compare("child_heading", got.heading, want.heading);
            compare("child_index", got.index, want.index);
            compare("last_child", got.last_child, want.last_child);
            compare("expansion_done", got.done, want.done);
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_idx;
    logic [23:0]            i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    t_child_scoreboard sb;
    bit                tx_steady;
    bit                rx_steady;
    int                cycle_count = 0;

    heading_successor_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_parent(t_parent p);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.offset, p.gspd, p.climb, p.heading, p.pos_z, p.pos_y, p.pos_x};
        s_axis_tlast  <= p.last_heading;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_parent(p);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Drops valid, then waits for every child and for any input that yields none.
    task automatic end_phase();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_children.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_coord(bit near_edge);
        if (!near_edge) return $urandom();
        return $urandom_range(0, 1) ? 32'h7F00_0000 + $urandom_range(0, 24'hFF_FFFF)
                                    : 32'h8000_0000 + $urandom_range(0, 24'hFF_FFFF);
    endfunction

    // Each parent is a well-formed run of heading offsets closed by last_heading,
    // with the odd run carrying a misplaced flag.
    task automatic random_expansions(int n_items);
        t_parent p;
        int      sent, runs;
        bit      near_edge;
        sent = 0;
        while (sent < n_items) begin
            near_edge = ($urandom_range(0, 7) == 0);
            p.pos_x   = random_coord(near_edge);
            p.pos_y   = random_coord(near_edge);
            p.pos_z   = random_coord(near_edge);
            p.heading = 16'($urandom_range(0, 16'hFFFF));
            p.climb   = 16'($urandom_range(0, 16'hFFFF));
            p.gspd    = 16'($urandom_range(0, 16'hFFFF));
            runs = $urandom_range(1, 5);
            for (int j = 0; j < runs; j++) begin
                p.offset       = 16'($urandom_range(0, 16'hFFFF));
                p.last_heading = (j == runs - 1);
                if ($urandom_range(0, 9) == 0) p.last_heading = 1'($urandom_range(0, 1));
                send_parent(p);
                sent++;
            end
        end
        end_phase();
    endtask

    initial begin : sink
        t_child got;
        int     gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.x          = m_axis_tdata[31:0];
            got.y          = m_axis_tdata[63:32];
            got.z          = m_axis_tdata[95:64];
            got.heading    = m_axis_tdata[111:96];
            got.index      = m_axis_tdata[135:112];
            got.last_child = m_axis_tlast;
            got.done       = m_axis_tuser;
            sb.check_child(got);
        end
    end

    initial begin : stimulus
        t_parent directed[$];
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_NUM_VERT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: cardinal headings, both fold boundaries, heading wrap,
        // field extremes and saturation in both directions.
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h0000, 16'sd0,
                                        16'h0000, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sd1000, -32'sd1000, 32'sd0, 16'h4000,
                                        16'sd256, 16'h0100, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h8000, -16'sd256,
                                        16'h0100, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'hC000, 16'sd1,
                                        16'h0100, 16'sd0, 1'b1}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'hFFFF, 16'sd0,
                                        16'h1000, 16'sd1, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h4001, 16'sd0,
                                        16'h1000, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'hBFFF, 16'sd0,
                                        16'h1000, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h3FFF, 16'sd0,
                                        16'h1000, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h0000, 16'sd0,
                                        16'hFFFF, 16'sh8000, 1'b0}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h1234, 16'sd0,
                                        16'hFFFF, 16'sh7FFF, 1'b1}};
        directed = {directed, t_parent'{32'sd5, 32'sd5, 32'sd5, 16'h2000, 16'sh7FFF,
                                        16'hFFFF, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{-32'sd5, -32'sd5, -32'sd5, 16'hE000, 16'sh8000,
                                        16'hFFFF, 16'sd0, 1'b1}};
        directed = {directed, t_parent'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                        16'h2000, 16'sh7FFF, 16'hFFFF, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        16'hA000, 16'sh8000, 16'hFFFF, 16'sd0, 1'b1}};
        directed = {directed, t_parent'{32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'sh5555_5555,
                                        16'hFFFF, -16'sd1, 16'h8000, -16'sd1, 1'b1}};
        foreach (directed[i]) send_parent(directed[i]);
        end_phase();

        // Child count above the limit, longest time step, node numbers about to wrap,
        // and a write to the unused index that must change nothing.
        write_reg(CFG_NUM_VERT, 24'd15);
        write_reg(CFG_TIME_STEP, 24'h00FFFF);
        write_reg(CFG_LIST_SIZE, 24'hFFFFFD);
        write_reg(CFG_SPARE, 24'($urandom()));
        directed.delete();
        directed = {directed, t_parent'{32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000,
                                        16'h2000, 16'sh7FFF, 16'hFFFF, 16'sd0, 1'b0}};
        directed = {directed, t_parent'{32'sh8000_FFFF, 32'sh8000_FFFF, 32'sh8000_FFFF,
                                        16'h6000, 16'sh8000, 16'hFFFF, 16'sh4000, 1'b1}};
        directed = {directed, t_parent'{32'sd0, 32'sd0, 32'sd0, 16'h0000, 16'sd0,
                                        16'h0000, 16'sd0, 1'b1}};
        foreach (directed[i]) send_parent(directed[i]);
        end_phase();

        // No children at all: the inputs vanish and the node count holds.
        write_reg(CFG_NUM_VERT, 24'd0);
        directed.delete();
        directed = {directed, t_parent'{32'sd77, 32'sd77, 32'sd77, 16'h1111, 16'sd9,
                                        16'h0200, 16'sd3, 1'b0}};
        directed = {directed, t_parent'{32'sd77, 32'sd77, 32'sd77, 16'h1111, 16'sd9,
                                        16'h0200, 16'sd5, 1'b1}};
        foreach (directed[i]) send_parent(directed[i]);
        end_phase();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       write_reg(CFG_NUM_VERT, 24'd8);
                1:       write_reg(CFG_NUM_VERT, 24'd1);
                2:       write_reg(CFG_NUM_VERT, 24'd9);
                default: write_reg(CFG_NUM_VERT, 24'($urandom_range(1, 15)));
            endcase
            case (phase)
                0:       write_reg(CFG_TIME_STEP, 24'h00FFFF);
                1:       write_reg(CFG_TIME_STEP, 24'd0);
                3:       write_reg(CFG_TIME_STEP, 24'($urandom_range(1, 1024)));
                default: write_reg(CFG_TIME_STEP, 24'($urandom_range(0, 16'hFFFF)));
            endcase
            if (phase == 2) write_reg(CFG_LIST_SIZE, 24'hFFFFF0);
            else write_reg(CFG_LIST_SIZE, 24'($urandom()));
            tx_steady = (phase == 3 || phase == 6);
            rx_steady = (phase == 1 || phase == 6);
            random_expansions(50);
        end

        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
